// File: src/lru_key_value_cache_core_defines.svh
// Assertion helpers shared by the cache RTL.
// Each check is clocked on i_clk and switched off while i_rst_n is low.
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define LKVC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define LKVC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/lkvc_pkg.sv
`default_nettype none

package lkvc_pkg;

    // Fixed field widths of the channels and the configuration register.
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    // Default number of entries held in registers.
    localparam int DEF_ENTRIES = 16;

    // Capacity after reset, and the value returned on a miss or a put.
    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    // Operation codes carried by the mode field.
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // take the input beat into the operand registers
        logic lookup;    // register the tag compare and the replacement choice
        logic commit;    // update the entries and load the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // the output register can take a new result this cycle
    } t_dp_status;

endpackage

`default_nettype wire

// File: src/lkvc_ctrl.sv
`default_nettype none

module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd,
    output logic            o_stall
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } t_state;

    t_state r_state, n_state;
    logic   r_stall, n_stall;

    // Next state and commands: one operation at a time, three phases.
    always_comb begin
        n_state      = r_state;
        n_stall      = r_stall;
        o_cmd        = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_LOOKUP;
                    n_stall       = 1'b1;
                end
            end
            ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = ST_UPDATE;
            end
            ST_UPDATE: begin
                // Wait here while an earlier result is still held by the receiver.
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                    n_stall      = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_stall = 1'b0;
            end
        endcase
    end

    // State and the registered stall towards the sender.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= n_stall;
        end
    end

    assign o_stall = r_stall;

endmodule

`default_nettype wire

// File: src/lkvc_dp.sv
`default_nettype none

module lkvc_dp
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
)
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_status              o_status,
    input  wire logic               i_mode,
    input  wire logic [KEY_W-1:0]   i_key,
    input  wire logic [VAL_W-1:0]   i_write_value,
    input  wire logic               i_cfg_we,
    input  wire logic [CAP_W-1:0]   i_cfg_wdata,
    input  wire logic               i_stall,
    output logic                    o_valid,
    output logic                    o_hit,
    output logic [VAL_W-1:0]        o_read_value,
    output logic                    o_evicted
);

    `include "lru_key_value_cache_core_defines.svh"

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Entry store: tags, valid marks and recency ranks in flops, values in memory.
    logic [KEY_W-1:0]   r_keys  [ENTRIES];
    logic [IDX_W-1:0]   r_rank  [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0]   r_count;
    logic [CAP_W-1:0]   r_cap;
    logic [VAL_W-1:0]   r_mem   [ENTRIES];

    // Operand registers of the operation in flight.
    logic               r_mode;
    logic [KEY_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_wval;

    // Lookup results.
    logic               r_hit;
    logic               r_full;
    logic [IDX_W-1:0]   r_hit_idx;
    logic [IDX_W-1:0]   r_hit_rank;
    logic [IDX_W-1:0]   r_slot_idx;

    // Output register.
    logic               r_out_valid;
    logic               r_out_hit;
    logic               r_out_evicted;
    logic [VAL_W-1:0]   r_out_value;

    logic [ENTRIES-1:0] w_match;
    logic [IDX_W-1:0]   w_hit_idx;
    logic [IDX_W-1:0]   w_hit_rank;
    logic [IDX_W-1:0]   w_free_idx;
    logic [IDX_W-1:0]   w_lru_idx;
    logic [CMP_W-1:0]   w_eff_cap;
    logic               w_full;
    logic [CNT_W-1:0]   w_lru_rank;
    logic               w_insert;
    logic               w_promote;
    logic [IDX_W-1:0]   w_idx;

    // Parallel tag compare; valid keys are unique, so at most one entry matches.
    always_comb begin
        w_hit_idx  = '0;
        w_hit_rank = '0;
        w_lru_idx  = '0;
        w_free_idx = '0;
        w_lru_rank = r_count - CNT_W'(1);
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_keys[i] == r_key);
            if (w_match[i]) begin
                w_hit_idx  = w_hit_idx | IDX_W'(i);
                w_hit_rank = w_hit_rank | r_rank[i];
            end
            // Ranks form a permutation, so only the oldest entry has rank count-1.
            if (r_valid[i] && (CNT_W'(r_rank[i]) == w_lru_rank)) begin
                w_lru_idx = w_lru_idx | IDX_W'(i);
            end
        end
        // Lowest free slot wins.
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_idx = IDX_W'(i);
            end
        end
    end

    // Usable capacity: zero counts as one, anything above the store as the store.
    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = CMP_W'(1);
        end else if (CMP_W'(r_cap) > CMP_W'(ENTRIES)) begin
            w_eff_cap = CMP_W'(ENTRIES);
        end else begin
            w_eff_cap = CMP_W'(r_cap);
        end
        w_full = CMP_W'(r_count) >= w_eff_cap;
    end

    // Operation decode for the update phase.
    assign w_insert  = !r_hit && (r_mode == MODE_PUT);
    assign w_promote = r_hit || (r_mode == MODE_PUT);
    assign w_idx     = r_hit ? r_hit_idx : r_slot_idx;

    // Operand capture and lookup registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_key  <= i_key;
            r_wval <= i_write_value;
        end
        if (i_cmd.lookup) begin
            r_hit      <= |w_match;
            r_full     <= w_full;
            r_hit_idx  <= w_hit_idx;
            r_hit_rank <= w_hit_rank;
            r_slot_idx <= w_full ? w_lru_idx : w_free_idx;
        end
    end

    // Control state of the store: valid marks, ranks, fill count and capacity.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_cap   <= CAP_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.commit && w_promote) begin
                // Age every valid entry more recent than the promoted one.
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i] && (IDX_W'(i) != w_idx)
                        && (!r_hit || (r_rank[i] < r_hit_rank))) begin
                        r_rank[i] <= r_rank[i] + IDX_W'(1);
                    end
                end
                r_rank[w_idx] <= '0;
            end
            if (i_cmd.commit && w_insert) begin
                r_valid[w_idx] <= 1'b1;
                // An eviction frees and refills the same slot.
                if (!r_full) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
        end
    end

    // Tag and value writes, value read and output payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_insert) begin
            r_keys[w_idx] <= r_key;
        end
        if (i_cmd.commit && (r_mode == MODE_PUT)) begin
            r_mem[w_idx] <= r_wval;
        end
        if (i_cmd.commit) begin
            r_out_hit     <= r_hit;
            r_out_evicted <= w_insert && r_full;
            r_out_value   <= (r_hit && (r_mode == MODE_GET)) ? r_mem[r_hit_idx] : MISS_VALUE;
        end
    end

    // Output beat handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_stall;
    assign o_valid           = r_out_valid;
    assign o_hit             = r_out_hit;
    assign o_read_value      = r_out_value;
    assign o_evicted         = r_out_evicted;

    // Checks on the entry bookkeeping.
    `LKVC_ASSERT_NOW(a_unique_match, 1'b1, $onehot0(w_match),
        "more than one entry matches the key")
    `LKVC_ASSERT_NOW(a_count_valid, 1'b1, $countones(r_valid) == int'(r_count),
        "fill count differs from valid marks")
    `LKVC_ASSERT_NOW(a_count_bound, 1'b1, int'(r_count) <= ENTRIES,
        "fill count exceeds the store")
    `LKVC_ASSERT_NEXT(a_insert_grows, i_cmd.commit && w_insert && !r_full,
        r_count == $past(r_count) + CNT_W'(1),
        "insert into free slot did not raise the count")

endmodule

`default_nettype wire

// File: src/lru_key_value_cache_core.sv
// Fully associative key/value cache with least-recently-used replacement.
// Input channel: i_valid with i_mode (0 get, 1 put), i_key and i_write_value;
// the block holds o_stall high while an operation is in flight, and a beat is
// taken at an edge where i_valid is high and o_stall is low.
// Output channel: one beat per input beat, o_valid with o_hit, o_read_value
// (stored value on a get hit, all ones otherwise) and o_evicted.
// The result is presented after the tag compare and then the entry update with
// the output register load. Operations do not overlap: each one passes through
// the compare phase and the update phase of the single entry store before the
// next beat is taken. A finished result waits in the output register while the
// next beat is taken; if the receiver still stalls when the next update is due,
// that update waits. Capacity is written through i_cfg_we and i_cfg_wdata; the
// user must do so only while the block is idle; the block does not enforce it.
// Synchronous reset empties the cache, sets the capacity to 16 and drops any
// pending output beat; no clearing pass is needed.
`default_nettype none

module lru_key_value_cache_core
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
)
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic                    i_mode,
    input  wire logic [KEY_W-1:0]        i_key,
    input  wire logic signed [VAL_W-1:0] i_write_value,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic                         o_hit,
    output logic signed [VAL_W-1:0]      o_read_value,
    output logic                         o_evicted,
    input  wire logic                    i_cfg_we,
    input  wire logic [CAP_W-1:0]        i_cfg_wdata
);

    t_dp_cmd          w_cmd;
    t_dp_status       w_status;
    logic [VAL_W-1:0] w_read_value;

    // Sequencer for the three phases of an operation.
    lkvc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_stall  (o_stall)
    );

    // Entry store, compare logic and output register.
    lkvc_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_mode        (i_mode),
        .i_key         (i_key),
        .i_write_value (i_write_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_hit         (o_hit),
        .o_read_value  (w_read_value),
        .o_evicted     (o_evicted)
    );

    assign o_read_value = signed'(w_read_value);

endmodule

`default_nettype wire

// File: test/lru_cache_checker.sv
// Watches both channels and the capacity port of the cache, predicts the result
// of every accepted input beat and compares each accepted result beat with the
// oldest prediction still waiting.
module lru_cache_checker
    import lkvc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_stall,
    input  wire logic             i_mode,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic [VAL_W-1:0] i_write_value,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_stall,
    input  wire logic             i_hit,
    input  wire logic [VAL_W-1:0] i_read_value,
    input  wire logic             i_evicted,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_wdata,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_hits,
    output int                    o_evictions
);

    localparam int ENTRIES = DEF_ENTRIES;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
    } t_cache_result;

    // Shadow copy of the cache contents and of the capacity register.
    logic [KEY_W-1:0] slot_key [ENTRIES];
    logic [VAL_W-1:0] slot_val [ENTRIES];
    logic             slot_live [ENTRIES];
    int               slot_age [ENTRIES];
    int               live_count;
    logic [CAP_W-1:0] capacity_reg;

    t_cache_result outstanding_results[$];

    // Makes one slot the most recent; valid entries younger than the limit age by one.
    function automatic void make_newest(input int slot, input int limit);
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_live[i] && i != slot && slot_age[i] < limit) begin
                slot_age[i]++;
            end
        end
        slot_age[slot] = 0;
    endfunction

    // Applies one operation to the shadow cache and returns the result it must give.
    function automatic t_cache_result lru_predict(input logic mode, input logic [KEY_W-1:0] key,
                                                  input logic [VAL_W-1:0] wval);
        t_cache_result res;
        int found;
        int victim;
        int oldest;
        int limit;
        found  = -1;
        victim = -1;
        oldest = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (found < 0 && slot_live[i] && slot_key[i] == key) begin
                found = i;
            end
        end
        res.hit        = (found >= 0);
        res.read_value = MISS_VALUE;
        res.evicted    = 1'b0;
        if (found >= 0) begin
            make_newest(found, slot_age[found]);
            if (mode == MODE_PUT) begin
                slot_val[found] = wval;
            end else begin
                res.read_value = slot_val[found];
            end
        end else if (mode == MODE_PUT) begin
            // A zero capacity behaves as one, anything above the store size as full size.
            limit = (capacity_reg == 0) ? 1 : int'(capacity_reg);
            if (limit > ENTRIES) begin
                limit = ENTRIES;
            end
            if (live_count >= limit) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot_live[i] && (victim < 0 || slot_age[i] > oldest)) begin
                        victim = i;
                        oldest = slot_age[i];
                    end
                end
                if (victim >= 0) begin
                    slot_live[victim] = 1'b0;
                    live_count--;
                    res.evicted = 1'b1;
                end
            end
            for (int i = 0; i < ENTRIES; i++) begin
                if (victim < 0 && !slot_live[i]) begin
                    victim = i;
                end
            end
            if (victim >= 0) begin
                slot_key[victim]  = key;
                slot_val[victim]  = wval;
                slot_live[victim] = 1'b1;
                live_count++;
                make_newest(victim, ENTRIES);
            end
        end
        return res;
    endfunction

    // Result beats are compared before the input beat of the same edge is predicted.
    always @(posedge i_clk) begin : watch_beats
        t_cache_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                slot_live[i] = 1'b0;
                slot_age[i]  = 0;
            end
            live_count   = 0;
            capacity_reg = CAP_RESET;
            outstanding_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_checked++;
                if (outstanding_results.size() == 0) begin
                    $error("result beat arrived with no operation outstanding");
                    o_fail_count++;
                end else begin
                    want = outstanding_results.pop_front();
                    if (want.hit) begin
                        o_hits++;
                    end
                    if (want.evicted) begin
                        o_evictions++;
                    end
                    if (i_hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, i_hit);
                        o_fail_count++;
                    end
                    if (i_read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               $signed(want.read_value), $signed(i_read_value));
                        o_fail_count++;
                    end
                    if (i_evicted !== want.evicted) begin
                        $error("evicted: expected %0d, got %0d", want.evicted, i_evicted);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                outstanding_results.push_back(lru_predict(i_mode, i_key, i_write_value));
            end
            if (i_cfg_we) begin
                capacity_reg = i_cfg_wdata;
            end
        end
        o_pending = outstanding_results.size();
    end

endmodule

// File: test/lru_key_value_cache_core_test.sv
// Drives get and put beats into the cache under random idling on both sides,
// walks the capacity through several settings and reports the verdict.
module lru_key_value_cache_core_test
    import lkvc_pkg::*;
();

    localparam int POOL_SIZE = 20;
    localparam int PHASE_OPS = 125;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_valid       = 1'b0;
    logic             o_stall;
    logic             i_mode        = MODE_GET;
    logic [KEY_W-1:0] i_key         = '0;
    logic [VAL_W-1:0] i_write_value = '0;
    logic             o_valid;
    logic             i_stall       = 1'b0;
    logic             o_hit;
    logic [VAL_W-1:0] o_read_value;
    logic             o_evicted;
    logic             i_cfg_we      = 1'b0;
    logic [CAP_W-1:0] i_cfg_wdata   = '0;

    int fail_count;
    int pending;
    int checked;
    int hits;
    int evictions;

    int   ops_sent     = 0;
    int   puts_sent    = 0;
    int   cap_settings = 0;
    logic calm         = 1'b0;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    lru_key_value_cache_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_key         (i_key),
        .i_write_value (i_write_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    lru_cache_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_mode        (i_mode),
        .i_key         (i_key),
        .i_write_value (i_write_value),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_hit         (o_hit),
        .i_read_value  (o_read_value),
        .i_evicted     (o_evicted),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_hits        (hits),
        .o_evictions   (evictions)
    );

    always #10 i_clk = ~i_clk;

    // The receiver stalls about a third of the time, except during the calm stretch.
    always @(negedge i_clk) begin
        i_stall <= !calm && ($urandom_range(0, 99) < 32);
    end

    // Presents one operation, idling at random first, and returns once the beat is taken.
    task automatic send_op(input logic mode, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] wval);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 32) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_mode        <= mode;
        i_key         <= key;
        i_write_value <= wval;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        ops_sent++;
        if (mode == MODE_PUT) begin
            puts_sent++;
        end
    endtask

    // Holds the input side quiet until every outstanding result has been taken.
    task automatic drain;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Capacity is only changed with the block idle, after the last result.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain();
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cap_settings++;
    endtask

    // Random gets and puts, mostly on a pool of keys just larger than the capacity.
    task automatic random_phase(input logic [CAP_W-1:0] cap);
        int usable;
        int pick;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] wval;
        usable = (cap == 0) ? 1 : ((cap > DEF_ENTRIES) ? DEF_ENTRIES : int'(cap));
        write_capacity(cap);
        for (int n = 0; n < PHASE_OPS; n++) begin
            // The sender waits for all results once per phase.
            if (n == PHASE_OPS / 2) begin
                drain();
            end
            calm = (ops_sent >= 500 && ops_sent < 650);
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                key = key_pool[$urandom_range(0, usable + 3)];
            end else if (pick < 95) begin
                key = $urandom;
            end else begin
                key = $urandom_range(0, 1) ? '1 : '0;
            end
            case ($urandom_range(0, 15))
                0: begin
                    wval = '1;
                end
                1: begin
                    wval = 32'h8000_0000;
                end
                2: begin
                    wval = 32'h7FFF_FFFF;
                end
                3: begin
                    wval = '0;
                end
                default: begin
                    wval = $urandom;
                end
            endcase
            send_op($urandom_range(0, 1) ? MODE_PUT : MODE_GET, key, wval);
        end
        calm = 1'b0;
    endtask

    initial begin
        logic [CAP_W-1:0] cap_plan [9];
        cap_plan = '{5'd16, 5'd2, 5'd1, 5'd31, 5'd0, 5'd4, 5'd17, 5'd8, 5'd0};
        cap_plan[8] = CAP_W'($urandom_range(0, 31));
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty lookup, extreme keys and values, update of a stored -1.
        send_op(MODE_GET, '0, '0);
        send_op(MODE_PUT, '0, 32'h7FFF_FFFF);
        send_op(MODE_PUT, '1, 32'h8000_0000);
        send_op(MODE_GET, '0, '0);
        send_op(MODE_GET, '1, '1);
        send_op(MODE_PUT, 32'h0000_1234, '1);
        send_op(MODE_PUT, 32'h0000_1234, 32'd5);
        send_op(MODE_GET, 32'h0000_1234, '0);
        send_op(MODE_PUT, '0, '0);
        send_op(MODE_GET, 32'hDEAD_BEEF, '0);
        send_op(MODE_GET, '0, '0);

        // Capacity dropped below the number held: each put miss swaps one entry.
        write_capacity(5'd1);
        send_op(MODE_PUT, 32'hA5A5_0001, 32'd11);
        send_op(MODE_GET, 32'hA5A5_0001, '0);
        send_op(MODE_PUT, 32'hA5A5_0002, 32'd12);
        send_op(MODE_GET, 32'h0000_1234, '0);

        // Zero capacity behaves as one.
        write_capacity(5'd0);
        send_op(MODE_PUT, 32'h5A5A_0003, 32'd13);
        send_op(MODE_PUT, 32'h5A5A_0004, 32'd14);
        send_op(MODE_GET, 32'h5A5A_0003, '0);
        send_op(MODE_GET, 32'h5A5A_0004, '0);

        // Capacity above the store size behaves as full size.
        write_capacity(5'd31);
        send_op(MODE_PUT, 32'hFFFF_0000, 32'hFFFF_FFFE);
        send_op(MODE_PUT, 32'h0000_FFFF, 32'h0000_0001);
        send_op(MODE_GET, 32'hFFFF_0000, '0);
        send_op(MODE_GET, 32'h0000_FFFF, '0);

        for (int p = 0; p < 9; p++) begin
            random_phase(cap_plan[p]);
        end

        drain();
        repeat (8) @(negedge i_clk);
        $display("Sent %0d operations (%0d puts) across %0d capacity settings.",
                 ops_sent, puts_sent, cap_settings);
        $display("Checked %0d results: %0d hits and %0d evictions.", checked, hits, evictions);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run.
    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
